// ===== hdl/bsjj_pkg.sv =====
package bsjj_pkg;

   // Field and datapath widths.
   localparam int VEC_W     = 20;
   localparam int VEC_N     = 3;
   localparam int QUAT_W    = 16;
   localparam int CFG_W     = 60;
   localparam int GAIN_W    = 16;
   localparam int PROD_W    = 32;
   localparam int MAT_W     = 34;
   localparam int TERM_W    = 54;
   localparam int SUM_W     = 56;
   localparam int ARM_W     = 28;
   localparam int ERR_W     = 30;
   localparam int GPROD_W   = 47;
   localparam int ROT_FRAC  = 28;
   localparam int GAIN_FRAC = 16;
   localparam int SAT_IN_W  = 32;

   localparam int NUM_STAGES = 7;
   localparam int NUM_BONES  = 2;
   localparam int NUM_PROD   = 9;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_OFFSET_A   = 2'd0;
   localparam logic [1:0] REG_OFFSET_B   = 2'd1;
   localparam logic [1:0] REG_ERROR_GAIN = 2'd2;

   // Slots of the quaternion product table.
   localparam int P_XX = 0;
   localparam int P_XY = 1;
   localparam int P_XZ = 2;
   localparam int P_YY = 3;
   localparam int P_YZ = 4;
   localparam int P_ZZ = 5;
   localparam int P_WX = 6;
   localparam int P_WY = 7;
   localparam int P_WZ = 8;

   typedef logic signed [VEC_W-1:0]    vec_comp_type;
   typedef logic signed [QUAT_W-1:0]   quat_comp_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [MAT_W-1:0]    mat_type;
   typedef logic signed [TERM_W-1:0]   term_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [ARM_W-1:0]    arm_type;
   typedef logic signed [ERR_W-1:0]    err_type;
   typedef logic signed [GPROD_W-1:0]  gprod_type;
   typedef logic signed [SAT_IN_W-1:0] sat_in_type;

   localparam mat_type   MAT_ONE   = MAT_W'(1) << ROT_FRAC;
   localparam sum_type   ROT_HALF  = SUM_W'(1) << (ROT_FRAC - 1);
   localparam gprod_type GAIN_HALF = GPROD_W'(1) << (GAIN_FRAC - 1);
   localparam sat_in_type VEC_MAX  = SAT_IN_W'((1 << (VEC_W - 1)) - 1);
   localparam sat_in_type VEC_MIN  = -SAT_IN_W'(1 << (VEC_W - 1));

   function automatic vec_comp_type vec_comp(input logic [CFG_W-1:0] packed_vec,
                                             input int idx);
      return vec_comp_type'(packed_vec[VEC_W*idx +: VEC_W]);
   endfunction

   function automatic quat_comp_type quat_comp(input logic [4*QUAT_W-1:0] packed_quat,
                                               input int idx);
      return quat_comp_type'(packed_quat[QUAT_W*idx +: QUAT_W]);
   endfunction

   function automatic vec_comp_type sat_vec(input sat_in_type value);
      vec_comp_type result;
      if (value > VEC_MAX) begin
         result = VEC_W'(VEC_MAX);
      end else if (value < VEC_MIN) begin
         result = VEC_W'(VEC_MIN);
      end else begin
         result = VEC_W'(value);
      end
      return result;
   endfunction

endpackage

// ===== hdl/ball_socket_joint_jacobian.sv =====
// Ball-socket joint evaluation: world arms rA, rB and the velocity bias.
// Throughput: one beat per cycle while the response side does not stall; seven
// pipeline stages, each with its own valid bit, so bubbles close up while the
// response side stalls.
// Reset (synchronous) empties the pipeline and clears all three registers.
module ball_socket_joint_jacobian (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [63:0]          req_orient_a,
   input  logic [59:0]          req_pos_a,
   input  logic [63:0]          req_orient_b,
   input  logic [59:0]          req_pos_b,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [19:0]   rsp_arm_a_x,
   output logic signed [19:0]   rsp_arm_a_y,
   output logic signed [19:0]   rsp_arm_a_z,
   output logic signed [19:0]   rsp_arm_b_x,
   output logic signed [19:0]   rsp_arm_b_y,
   output logic signed [19:0]   rsp_arm_b_z,
   output logic signed [19:0]   rsp_bias_x,
   output logic signed [19:0]   rsp_bias_y,
   output logic signed [19:0]   rsp_bias_z,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [59:0]          csr_wdata
);

   localparam int NS = bsjj_pkg::NUM_STAGES;
   localparam int NB = bsjj_pkg::NUM_BONES;
   localparam int NV = bsjj_pkg::VEC_N;
   localparam int NP = bsjj_pkg::NUM_PROD;

   // Configuration registers.
   logic [bsjj_pkg::CFG_W-1:0]  offset_a_ff;
   logic [bsjj_pkg::CFG_W-1:0]  offset_b_ff;
   logic [bsjj_pkg::GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_a_ff <= '0;
         offset_b_ff <= '0;
         gain_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            bsjj_pkg::REG_OFFSET_A:   offset_a_ff <= csr_wdata;
            bsjj_pkg::REG_OFFSET_B:   offset_b_ff <= csr_wdata;
            bsjj_pkg::REG_ERROR_GAIN: gain_ff     <= csr_wdata[bsjj_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control.
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] stage_ready;
   logic [NS-1:0] load;

   always_comb begin
      stage_ready[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int s = NS - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            load[s]     = stage_ready[s] && req_valid;
            valid_in[s] = stage_ready[s] ? req_valid : valid_ff[s];
         end else begin
            load[s]     = stage_ready[s] && valid_ff[s-1];
            valid_in[s] = stage_ready[s] ? valid_ff[s-1] : valid_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_ready[0];
   assign rsp_valid = valid_ff[NS-1];

   // Stage 1: quaternion component products, unpacked positions.
   bsjj_pkg::prod_type     prod1_in [NB][NP];
   bsjj_pkg::prod_type     prod1_ff [NB][NP];
   bsjj_pkg::vec_comp_type pos1_in  [NB][NV];
   bsjj_pkg::vec_comp_type pos1_ff  [NB][NV];

   always_comb begin
      logic [63:0] quat;
      logic [59:0] pos;
      bsjj_pkg::prod_type qx, qy, qz, qw;
      for (int j = 0; j < NB; j++) begin
         quat = (j == 0) ? req_orient_a : req_orient_b;
         pos  = (j == 0) ? req_pos_a : req_pos_b;
         qx = bsjj_pkg::PROD_W'(bsjj_pkg::quat_comp(quat, 0));
         qy = bsjj_pkg::PROD_W'(bsjj_pkg::quat_comp(quat, 1));
         qz = bsjj_pkg::PROD_W'(bsjj_pkg::quat_comp(quat, 2));
         qw = bsjj_pkg::PROD_W'(bsjj_pkg::quat_comp(quat, 3));
         prod1_in[j][bsjj_pkg::P_XX] = qx * qx;
         prod1_in[j][bsjj_pkg::P_XY] = qx * qy;
         prod1_in[j][bsjj_pkg::P_XZ] = qx * qz;
         prod1_in[j][bsjj_pkg::P_YY] = qy * qy;
         prod1_in[j][bsjj_pkg::P_YZ] = qy * qz;
         prod1_in[j][bsjj_pkg::P_ZZ] = qz * qz;
         prod1_in[j][bsjj_pkg::P_WX] = qw * qx;
         prod1_in[j][bsjj_pkg::P_WY] = qw * qy;
         prod1_in[j][bsjj_pkg::P_WZ] = qw * qz;
         for (int k = 0; k < NV; k++) begin
            pos1_in[j][k] = bsjj_pkg::vec_comp(pos, k);
         end
      end
   end

   // Stage 2: rotation matrix entries in Q.28.
   bsjj_pkg::mat_type      mat2_in [NB][NP];
   bsjj_pkg::mat_type      mat2_ff [NB][NP];
   bsjj_pkg::vec_comp_type pos2_ff [NB][NV];

   always_comb begin
      bsjj_pkg::mat_type e [NP];
      for (int j = 0; j < NB; j++) begin
         for (int p = 0; p < NP; p++) begin
            e[p] = bsjj_pkg::MAT_W'(prod1_ff[j][p]);
         end
         mat2_in[j][0] = bsjj_pkg::MAT_ONE - ((e[bsjj_pkg::P_YY] + e[bsjj_pkg::P_ZZ]) <<< 1);
         mat2_in[j][1] = (e[bsjj_pkg::P_XY] - e[bsjj_pkg::P_WZ]) <<< 1;
         mat2_in[j][2] = (e[bsjj_pkg::P_XZ] + e[bsjj_pkg::P_WY]) <<< 1;
         mat2_in[j][3] = (e[bsjj_pkg::P_XY] + e[bsjj_pkg::P_WZ]) <<< 1;
         mat2_in[j][4] = bsjj_pkg::MAT_ONE - ((e[bsjj_pkg::P_XX] + e[bsjj_pkg::P_ZZ]) <<< 1);
         mat2_in[j][5] = (e[bsjj_pkg::P_YZ] - e[bsjj_pkg::P_WX]) <<< 1;
         mat2_in[j][6] = (e[bsjj_pkg::P_XZ] - e[bsjj_pkg::P_WY]) <<< 1;
         mat2_in[j][7] = (e[bsjj_pkg::P_YZ] + e[bsjj_pkg::P_WX]) <<< 1;
         mat2_in[j][8] = bsjj_pkg::MAT_ONE - ((e[bsjj_pkg::P_XX] + e[bsjj_pkg::P_YY]) <<< 1);
      end
   end

   // Stage 3: offset component times matrix entry, one product per entry.
   bsjj_pkg::term_type     term3_in [NB][NP];
   bsjj_pkg::term_type     term3_ff [NB][NP];
   bsjj_pkg::vec_comp_type pos3_ff  [NB][NV];

   always_comb begin
      logic [59:0] offset;
      bsjj_pkg::term_type v;
      for (int j = 0; j < NB; j++) begin
         offset = (j == 0) ? offset_a_ff : offset_b_ff;
         for (int i = 0; i < NV; i++) begin
            for (int k = 0; k < NV; k++) begin
               v = bsjj_pkg::TERM_W'(bsjj_pkg::vec_comp(offset, k));
               term3_in[j][NV*i+k] = v * bsjj_pkg::TERM_W'(mat2_ff[j][NV*i+k]);
            end
         end
      end
   end

   // Stage 4: row sums rounded half up to Q.10, kept at full width.
   bsjj_pkg::arm_type      arm4_in [NB][NV];
   bsjj_pkg::arm_type      arm4_ff [NB][NV];
   bsjj_pkg::vec_comp_type pos4_ff [NB][NV];

   always_comb begin
      bsjj_pkg::sum_type acc;
      for (int j = 0; j < NB; j++) begin
         for (int i = 0; i < NV; i++) begin
            acc = bsjj_pkg::SUM_W'(term3_ff[j][NV*i])
                + bsjj_pkg::SUM_W'(term3_ff[j][NV*i+1])
                + bsjj_pkg::SUM_W'(term3_ff[j][NV*i+2])
                + bsjj_pkg::ROT_HALF;
            arm4_in[j][i] = bsjj_pkg::ARM_W'(acc >>> bsjj_pkg::ROT_FRAC);
         end
      end
   end

   // Stage 5: position error between the anchors, saturated arms.
   bsjj_pkg::err_type      err5_in [NV];
   bsjj_pkg::err_type      err5_ff [NV];
   bsjj_pkg::vec_comp_type sat5_in [NB][NV];
   bsjj_pkg::vec_comp_type sat5_ff [NB][NV];

   always_comb begin
      for (int i = 0; i < NV; i++) begin
         err5_in[i] = (bsjj_pkg::ERR_W'(pos4_ff[1][i]) + bsjj_pkg::ERR_W'(arm4_ff[1][i]))
                    - (bsjj_pkg::ERR_W'(pos4_ff[0][i]) + bsjj_pkg::ERR_W'(arm4_ff[0][i]));
         for (int j = 0; j < NB; j++) begin
            sat5_in[j][i] = bsjj_pkg::sat_vec(bsjj_pkg::SAT_IN_W'(arm4_ff[j][i]));
         end
      end
   end

   // Stage 6: error times the unsigned gain.
   bsjj_pkg::gprod_type    gprod6_in [NV];
   bsjj_pkg::gprod_type    gprod6_ff [NV];
   bsjj_pkg::vec_comp_type sat6_ff   [NB][NV];

   always_comb begin
      bsjj_pkg::gprod_type gain;
      gain = bsjj_pkg::GPROD_W'(signed'({1'b0, gain_ff}));
      for (int i = 0; i < NV; i++) begin
         gprod6_in[i] = bsjj_pkg::GPROD_W'(err5_ff[i]) * gain;
      end
   end

   // Stage 7: bias rounded half up from Q.26 to Q.10 and saturated.
   bsjj_pkg::vec_comp_type bias7_in [NV];
   bsjj_pkg::vec_comp_type bias7_ff [NV];
   bsjj_pkg::vec_comp_type sat7_ff  [NB][NV];

   always_comb begin
      bsjj_pkg::gprod_type rounded;
      for (int i = 0; i < NV; i++) begin
         rounded     = (gprod6_ff[i] + bsjj_pkg::GAIN_HALF) >>> bsjj_pkg::GAIN_FRAC;
         bias7_in[i] = bsjj_pkg::sat_vec(bsjj_pkg::SAT_IN_W'(rounded));
      end
   end

   // Payload registers load only when their stage takes a new beat.
   always_ff @(posedge clock) begin
      if (load[0]) begin
         prod1_ff <= prod1_in;
         pos1_ff  <= pos1_in;
      end
      if (load[1]) begin
         mat2_ff <= mat2_in;
         pos2_ff <= pos1_ff;
      end
      if (load[2]) begin
         term3_ff <= term3_in;
         pos3_ff  <= pos2_ff;
      end
      if (load[3]) begin
         arm4_ff <= arm4_in;
         pos4_ff <= pos3_ff;
      end
      if (load[4]) begin
         err5_ff <= err5_in;
         sat5_ff <= sat5_in;
      end
      if (load[5]) begin
         gprod6_ff <= gprod6_in;
         sat6_ff   <= sat5_ff;
      end
      if (load[6]) begin
         bias7_ff <= bias7_in;
         sat7_ff  <= sat6_ff;
      end
   end

   assign rsp_arm_a_x = sat7_ff[0][0];
   assign rsp_arm_a_y = sat7_ff[0][1];
   assign rsp_arm_a_z = sat7_ff[0][2];
   assign rsp_arm_b_x = sat7_ff[1][0];
   assign rsp_arm_b_y = sat7_ff[1][1];
   assign rsp_arm_b_z = sat7_ff[1][2];
   assign rsp_bias_x  = bias7_ff[0];
   assign rsp_bias_y  = bias7_ff[1];
   assign rsp_bias_z  = bias7_ff[2];

endmodule

// ===== tb/ball_socket_joint_jacobian_tb.sv =====
module ball_socket_joint_jacobian_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The configuration port has four slots, but only three registers exist.
   localparam logic [1:0] REG_NONE = 2'd3;

   localparam int ARM_MAX = 524287;
   localparam int ARM_MIN = -524288;

   typedef struct packed {
      logic [63:0] orient_a;
      logic [59:0] pos_a;
      logic [63:0] orient_b;
      logic [59:0] pos_b;
   } joint_type;

   // Element 0..2 is rA, 3..5 is rB, 6..8 is the bias, x first in each.
   typedef logic [8:0][bsjj_pkg::VEC_W-1:0] joint_result_type;

   typedef struct packed {
      logic             is_write;
      logic [1:0]       reg_idx;
      logic [59:0]      wdata;
      logic             typed;
      joint_type        joint;
      joint_result_type result;
   } step_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [63:0]         req_orient_a = '0;
   logic [59:0]         req_pos_a = '0;
   logic [63:0]         req_orient_b = '0;
   logic [59:0]         req_pos_b = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [19:0]  rsp_arm_a_x;
   logic signed [19:0]  rsp_arm_a_y;
   logic signed [19:0]  rsp_arm_a_z;
   logic signed [19:0]  rsp_arm_b_x;
   logic signed [19:0]  rsp_arm_b_y;
   logic signed [19:0]  rsp_arm_b_z;
   logic signed [19:0]  rsp_bias_x;
   logic signed [19:0]  rsp_bias_y;
   logic signed [19:0]  rsp_bias_z;
   logic                csr_write = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [59:0]         csr_wdata = '0;

   // Shadow copy of the block's registers.
   logic [59:0]         anchor_a_local = '0;
   logic [59:0]         anchor_b_local = '0;
   logic [15:0]         gain_shadow = '0;

   joint_result_type    pending_results [$];
   step_type            plan [$];
   int                  fail_count = 0;
   int                  send_idle_pct = 20;
   int                  recv_stall_pct = 60;
   string               field_name [9] = '{"arm_a_x", "arm_a_y", "arm_a_z",
                                           "arm_b_x", "arm_b_y", "arm_b_z",
                                           "bias_x", "bias_y", "bias_z"};

   ball_socket_joint_jacobian i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_orient_a (req_orient_a),
      .req_pos_a    (req_pos_a),
      .req_orient_b (req_orient_b),
      .req_pos_b    (req_pos_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_arm_a_x  (rsp_arm_a_x),
      .rsp_arm_a_y  (rsp_arm_a_y),
      .rsp_arm_a_z  (rsp_arm_a_z),
      .rsp_arm_b_x  (rsp_arm_b_x),
      .rsp_arm_b_y  (rsp_arm_b_y),
      .rsp_arm_b_z  (rsp_arm_b_z),
      .rsp_bias_x   (rsp_bias_x),
      .rsp_bias_y   (rsp_bias_y),
      .rsp_bias_z   (rsp_bias_z),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [59:0] vec3(input int x, input int y, input int z);
      return {z[19:0], y[19:0], x[19:0]};
   endfunction

   function automatic logic [63:0] quat(input int x, input int y, input int z, input int w);
      return {w[15:0], z[15:0], y[15:0], x[15:0]};
   endfunction

   function automatic joint_type make_joint(input logic [63:0] qa, input logic [59:0] pa,
                                            input logic [63:0] qb, input logic [59:0] pb);
      joint_type j;
      j.orient_a = qa;
      j.pos_a    = pa;
      j.orient_b = qb;
      j.pos_b    = pb;
      return j;
   endfunction

   function automatic step_type item_row(input joint_type j);
      step_type s;
      s = '0;
      s.joint = j;
      return s;
   endfunction

   function automatic step_type checked_row(input joint_type j, input joint_result_type r);
      step_type s;
      s = item_row(j);
      s.typed  = 1'b1;
      s.result = r;
      return s;
   endfunction

   function automatic step_type write_row(input logic [1:0] idx, input logic [59:0] data);
      step_type s;
      s = '0;
      s.is_write = 1'b1;
      s.reg_idx  = idx;
      s.wdata    = data;
      return s;
   endfunction

   // Divide by 2^sh, rounding half up.
   function automatic longint round_down_shift(input longint x, input int sh);
      return (x + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic logic [bsjj_pkg::VEC_W-1:0] clamp_vec(input longint v);
      if (v > ARM_MAX) begin
         return bsjj_pkg::VEC_W'(ARM_MAX);
      end else if (v < ARM_MIN) begin
         return bsjj_pkg::VEC_W'(ARM_MIN);
      end
      return v[bsjj_pkg::VEC_W-1:0];
   endfunction

   // Rotates a local anchor offset into world space, unrounded matrix in Q.28.
   function automatic logic [2:0][63:0] rotate_offset(input logic [59:0] offs,
                                                      input logic [63:0] q);
      longint vx, vy, vz, qx, qy, qz, qw;
      longint xx, xy, xz, yy, yz, zz, wx, wy, wz, unit;
      logic [2:0][63:0] arm;
      vx = longint'($signed(offs[19:0]));
      vy = longint'($signed(offs[39:20]));
      vz = longint'($signed(offs[59:40]));
      qx = longint'($signed(q[15:0]));
      qy = longint'($signed(q[31:16]));
      qz = longint'($signed(q[47:32]));
      qw = longint'($signed(q[63:48]));
      xx = 2 * qx * qx;
      xy = 2 * qx * qy;
      xz = 2 * qx * qz;
      yy = 2 * qy * qy;
      yz = 2 * qy * qz;
      zz = 2 * qz * qz;
      wx = 2 * qw * qx;
      wy = 2 * qw * qy;
      wz = 2 * qw * qz;
      unit = longint'(1) <<< bsjj_pkg::ROT_FRAC;
      arm[0] = round_down_shift(vx * (unit - yy - zz) + vy * (xy - wz) + vz * (xz + wy),
                                bsjj_pkg::ROT_FRAC);
      arm[1] = round_down_shift(vx * (xy + wz) + vy * (unit - xx - zz) + vz * (yz - wx),
                                bsjj_pkg::ROT_FRAC);
      arm[2] = round_down_shift(vx * (xz - wy) + vy * (yz + wx) + vz * (unit - xx - yy),
                                bsjj_pkg::ROT_FRAC);
      return arm;
   endfunction

   function automatic joint_result_type predict_joint(input joint_type j);
      logic [2:0][63:0] arm_a, arm_b;
      longint anchor_gap, gain;
      joint_result_type r;
      arm_a = rotate_offset(anchor_a_local, j.orient_a);
      arm_b = rotate_offset(anchor_b_local, j.orient_b);
      gain  = longint'(gain_shadow);
      for (int i = 0; i < 3; i++) begin
         // The anchors use the rounded arms before saturation.
         anchor_gap = (longint'($signed(j.pos_b[20*i +: 20])) + $signed(arm_b[i]))
                    - (longint'($signed(j.pos_a[20*i +: 20])) + $signed(arm_a[i]));
         r[i]     = clamp_vec($signed(arm_a[i]));
         r[3 + i] = clamp_vec($signed(arm_b[i]));
         r[6 + i] = clamp_vec(round_down_shift(anchor_gap * gain, bsjj_pkg::GAIN_FRAC));
      end
      return r;
   endfunction

   function automatic logic [59:0] small_vec();
      return vec3(int'($urandom_range(8191)) - 4096, int'($urandom_range(8191)) - 4096,
                  int'($urandom_range(8191)) - 4096);
   endfunction

   function automatic logic [59:0] random_pos();
      if ($urandom_range(1) == 0) begin
         return 60'({$urandom(), $urandom()});
      end
      return small_vec();
   endfunction

   // Half raw bit patterns, the rest unit-length or shorter rotations.
   function automatic logic [63:0] random_quat();
      logic [63:0] q;
      q = '0;
      case ($urandom_range(3))
         0, 1: begin
            q = {$urandom(), $urandom()};
         end
         2: begin
            q = quat(int'($urandom_range(16383)) - 8192, int'($urandom_range(16383)) - 8192,
                     int'($urandom_range(16383)) - 8192, int'($urandom_range(16383)) - 8192);
         end
         default: begin
            q[16*$urandom_range(3) +: 16] = ($urandom_range(1) == 0) ? 16'sd16384 : -16'sd16384;
         end
      endcase
      return q;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [59:0] data);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         bsjj_pkg::REG_OFFSET_A:   anchor_a_local = data;
         bsjj_pkg::REG_OFFSET_B:   anchor_b_local = data;
         bsjj_pkg::REG_ERROR_GAIN: gain_shadow = data[15:0];
         default: ;
      endcase
   endtask

   task automatic send_joint(input joint_type j, input logic typed, input joint_result_type r);
      csr_write <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_orient_a <= j.orient_a;
      req_pos_a    <= j.pos_a;
      req_orient_b <= j.orient_b;
      req_pos_b    <= j.pos_b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(typed ? r : predict_joint(j));
   endtask

   always @(posedge clock) begin
      joint_result_type seen, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_bias_z, rsp_bias_y, rsp_bias_x, rsp_arm_b_z, rsp_arm_b_y, rsp_arm_b_x,
                 rsp_arm_a_z, rsp_arm_a_y, rsp_arm_a_x};
         if (pending_results.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            for (int i = 0; i < 9; i++) begin
               if (seen[i] !== want[i]) begin
                  $error("%s: expected %0d, got %0d", field_name[i], $signed(want[i]),
                         $signed(seen[i]));
                  fail_count++;
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   initial begin
      logic [59:0] offs_a, offs_b;
      logic [15:0] gain;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Registers are still clear: every output is zero whatever comes in.
      plan.push_back(checked_row(make_joint('0, '0, '0, '0), '0));
      plan.push_back(checked_row(make_joint({64{1'b1}}, {60{1'b1}}, {64{1'b1}}, {60{1'b1}}),
                                 '0));
      plan.push_back(checked_row(make_joint(quat(-32768, -32768, -32768, -32768),
                                            vec3(ARM_MAX, ARM_MAX, ARM_MAX),
                                            quat(32767, 32767, 32767, 32767),
                                            vec3(ARM_MIN, ARM_MIN, ARM_MIN)), '0));
      // With no gain the bias stays zero; zero vector part means no rotation.
      plan.push_back(write_row(bsjj_pkg::REG_OFFSET_A, vec3(1000, -2000, ARM_MAX)));
      plan.push_back(write_row(bsjj_pkg::REG_OFFSET_B, vec3(ARM_MIN, 3, -1)));
      plan.push_back(checked_row(make_joint('0, vec3(5, 6, 7), '0, vec3(-8, 9, -10)),
                                 {60'd0, vec3(ARM_MIN, 3, -1), vec3(1000, -2000, ARM_MAX)}));
      plan.push_back(checked_row(make_joint(quat(0, 0, 0, 16384), '0, quat(0, 0, 0, 16384), '0),
                                 {60'd0, vec3(ARM_MIN, 3, -1), vec3(1000, -2000, ARM_MAX)}));
      // Half turns about x and y; negating the most negative component saturates.
      plan.push_back(checked_row(make_joint(quat(16384, 0, 0, 0), '0, quat(0, 16384, 0, 0), '0),
                                 {60'd0, vec3(ARM_MAX, 3, 1), vec3(1000, 2000, -ARM_MAX)}));
      plan.push_back(write_row(bsjj_pkg::REG_ERROR_GAIN, 60'hFFFF));
      plan.push_back(item_row(make_joint('0, vec3(ARM_MAX, ARM_MAX, ARM_MAX),
                                         '0, vec3(ARM_MIN, ARM_MIN, ARM_MIN))));
      plan.push_back(item_row(make_joint('0, vec3(ARM_MIN, ARM_MIN, ARM_MIN),
                                         '0, vec3(ARM_MAX, ARM_MAX, ARM_MAX))));
      plan.push_back(item_row(make_joint(quat(32767, 32767, 32767, 32767), vec3(1, 2, 3),
                                         quat(32767, 32767, 32767, 32767), vec3(-1, -2, -3))));
      plan.push_back(item_row(make_joint(quat(-32768, -32768, -32768, -32768), '0,
                                         quat(-32768, 0, -32768, 0), '0)));
      plan.push_back(item_row(make_joint(quat(0, 0, 11585, 11585), vec3(100, 200, 300),
                                         quat(11585, 0, 0, -11585), vec3(-300, 200, -100))));
      // Rounding at exactly one half goes up, just below or above does not.
      plan.push_back(write_row(bsjj_pkg::REG_OFFSET_A, '0));
      plan.push_back(write_row(bsjj_pkg::REG_OFFSET_B, '0));
      plan.push_back(write_row(bsjj_pkg::REG_ERROR_GAIN, 60'd1));
      plan.push_back(checked_row(make_joint('0, '0, '0, vec3(32768, 32767, -32769)),
                                 {vec3(1, 0, -1), 60'd0, 60'd0}));
      plan.push_back(write_row(bsjj_pkg::REG_OFFSET_A, vec3(1, 0, 0)));
      plan.push_back(write_row(bsjj_pkg::REG_OFFSET_B, vec3(-1, 0, 0)));
      plan.push_back(checked_row(make_joint(quat(0, 8192, 0, 0), '0, quat(0, 8192, 0, 0), '0),
                                 {60'd0, 60'd0, vec3(1, 0, 0)}));
      // A write to the unused slot must leave every register alone.
      plan.push_back(write_row(REG_NONE, {60{1'b1}}));
      plan.push_back(checked_row(make_joint(quat(0, 8192, 0, 0), '0, quat(0, 8192, 0, 0), '0),
                                 {60'd0, 60'd0, vec3(1, 0, 0)}));

      foreach (plan[n]) begin
         if (plan[n].is_write) begin
            write_reg(plan[n].reg_idx, plan[n].wdata);
         end else begin
            send_joint(plan[n].joint, plan[n].typed, plan[n].result);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct  = (ph == 0) ? 20 : (ph == 1) ? 60 : 0;
         recv_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 20 : 0;
         for (int s = 0; s < 4; s++) begin
            case ((ph + s) % 4)
               0: begin
                  offs_a = 60'({$urandom(), $urandom()});
                  offs_b = 60'({$urandom(), $urandom()});
                  gain   = 16'($urandom());
               end
               1: begin
                  offs_a = vec3(ARM_MAX, ARM_MAX, ARM_MAX);
                  offs_b = vec3(ARM_MAX, ARM_MAX, ARM_MAX);
                  gain   = 16'hFFFF;
               end
               2: begin
                  offs_a = vec3(ARM_MIN, ARM_MIN, ARM_MIN);
                  offs_b = vec3(ARM_MIN, ARM_MIN, ARM_MIN);
                  gain   = '0;
               end
               default: begin
                  offs_a = small_vec();
                  offs_b = small_vec();
                  gain   = 16'($urandom());
               end
            endcase
            write_reg(bsjj_pkg::REG_OFFSET_A, offs_a);
            write_reg(bsjj_pkg::REG_OFFSET_B, offs_b);
            write_reg(bsjj_pkg::REG_ERROR_GAIN, {44'd0, gain});
            for (int k = 0; k < 34; k++) begin
               send_joint(make_joint(random_quat(), random_pos(), random_quat(), random_pos()),
                          1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (bsjj_pkg::NUM_STAGES + 4) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
